/* hw/rtl/spif_pkg.sv */
package spif_pkg;

  // fixed field widths of the spike requests
  localparam int unsigned CH_W      = 4;
  localparam int unsigned ROW_W     = 4;
  localparam int unsigned COL_W     = 4;
  localparam int unsigned OUT_ROW_W = 3;
  localparam int unsigned OUT_COL_W = 3;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_DATA_W-1:0] THRESHOLD_RESET = 16'd256;
  localparam logic [CFG_DATA_W-1:0] WEIGHT_RESET    = 16'd64;

  // default geometry
  localparam int unsigned CHANNELS_DEFAULT       = 16;
  localparam int unsigned POOLED_SIZE_DEFAULT    = 8;
  localparam int unsigned POTENTIAL_BITS_DEFAULT = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FIRE_THRESHOLD = 2'd0,
    REG_SPIKE_WEIGHT   = 2'd1
  } cfg_reg_t;

endpackage

/* hw/rtl/spif_pot_ram.sv */
module spif_pot_ram #(
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned ADDR_W = 10,
  parameter int unsigned DATA_W = 16
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // single write port, registered read with old data on collision
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/spiking_pool_integrate_fire_unit.sv */
// a request is registered in the update stage and its pooled spike in the output register
// throughput: one spike request per cycle, one potential read and one write-back each,
// unless stalled: a request is held in the update stage while the output register is full
// and not taken. reset: synchronous; the potential memory is then cleared one cell a cycle
// through all CHANNELS*POOLED_SIZE*POOLED_SIZE cells (1024 by default) with in_ready low
// reset sets fire_threshold to 256 and spike_weight to 64; config writes are always taken
module spiking_pool_integrate_fire_unit #(
  parameter int unsigned CHANNELS       = spif_pkg::CHANNELS_DEFAULT,
  parameter int unsigned POOLED_SIZE    = spif_pkg::POOLED_SIZE_DEFAULT,
  parameter int unsigned POTENTIAL_BITS = spif_pkg::POTENTIAL_BITS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [spif_pkg::CH_W-1:0]          channel,
  input  logic [spif_pkg::ROW_W-1:0]         row,
  input  logic [spif_pkg::COL_W-1:0]         col,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [spif_pkg::CH_W-1:0]          out_channel,
  output logic [spif_pkg::OUT_ROW_W-1:0]     out_row,
  output logic [spif_pkg::OUT_COL_W-1:0]     out_col,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [spif_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [spif_pkg::CFG_DATA_W-1:0]    cfg_data
);

  import spif_pkg::*;

  localparam int unsigned CELL_COUNT = CHANNELS * POOLED_SIZE * POOLED_SIZE;
  localparam int unsigned ADDR_W     = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int unsigned SUM_W      =
    ((POTENTIAL_BITS > CFG_DATA_W) ? POTENTIAL_BITS : CFG_DATA_W) + 1;
  localparam logic [SUM_W-1:0]  POT_MAX   =
    {{(SUM_W-POTENTIAL_BITS){1'b0}}, {POTENTIAL_BITS{1'b1}}};
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELL_COUNT - 1);

  // configuration registers
  logic [CFG_DATA_W-1:0] fire_threshold;
  logic [CFG_DATA_W-1:0] spike_weight;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fire_threshold <= THRESHOLD_RESET;
      spike_weight   <= WEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_FIRE_THRESHOLD: fire_threshold <= cfg_data;
        REG_SPIKE_WEIGHT:   spike_weight   <= cfg_data;
        default: ;
      endcase
    end
  end

  // clearing sweep after reset
  logic              clr_active;
  logic [ADDR_W-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == LAST_ADDR) begin
        clr_active <= 1'b0;
      end
    end
  end

  // request decode: pooled coordinates, cell address, range check
  logic [OUT_ROW_W-1:0] in_prow;
  logic [OUT_COL_W-1:0] in_pcol;
  logic [ADDR_W-1:0]    in_addr;
  logic                 in_hit;
  logic                 in_accept;

  assign in_prow = row[ROW_W-1:1];
  assign in_pcol = col[COL_W-1:1];
  assign in_addr = ADDR_W'(32'(channel) * 32'(POOLED_SIZE * POOLED_SIZE)
                         + 32'(in_prow) * 32'(POOLED_SIZE) + 32'(in_pcol));
  assign in_hit  = (32'(channel) < 32'(CHANNELS)) && (32'(in_prow) < 32'(POOLED_SIZE))
                && (32'(in_pcol) < 32'(POOLED_SIZE));

  // update stage registers
  logic                  s1_valid;
  logic                  s1_hit;
  logic [ADDR_W-1:0]     s1_addr;
  logic [CH_W-1:0]       s1_channel;
  logic [OUT_ROW_W-1:0]  s1_prow;
  logic [OUT_COL_W-1:0]  s1_pcol;
  logic                  s1_go;

  assign s1_go     = !out_valid || out_ready;
  assign in_ready  = !clr_active && (!s1_valid || s1_go);
  assign in_accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_hit     <= in_hit;
      s1_addr    <= in_addr;
      s1_channel <= channel;
      s1_prow    <= in_prow;
      s1_pcol    <= in_pcol;
    end
  end

  // potential memory
  logic                      mem_we;
  logic [ADDR_W-1:0]         mem_waddr;
  logic [POTENTIAL_BITS-1:0] mem_wdata;
  logic [POTENTIAL_BITS-1:0] mem_rdata;
  logic                      s1_write;
  logic [POTENTIAL_BITS-1:0] s1_new_pot;

  spif_pot_ram #(
    .DEPTH  (CELL_COUNT),
    .ADDR_W (ADDR_W),
    .DATA_W (POTENTIAL_BITS)
  ) u_pot_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (in_accept),
    .raddr (in_addr),
    .rdata (mem_rdata)
  );

  assign s1_write  = s1_valid && s1_hit && s1_go;
  assign mem_we    = clr_active || s1_write;
  assign mem_waddr = clr_active ? clr_addr : s1_addr;
  assign mem_wdata = clr_active ? '0 : s1_new_pot;

  // forwarding of the last write-back, which the following read misses
  logic                      fwd_valid;
  logic [ADDR_W-1:0]         fwd_addr;
  logic [POTENTIAL_BITS-1:0] fwd_data;

  always_ff @(posedge clk) begin
    if (rst || clr_active) begin
      fwd_valid <= 1'b0;
    end else if (s1_write) begin
      fwd_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_write) begin
      fwd_addr <= s1_addr;
      fwd_data <= s1_new_pot;
    end
  end

  // integrate with saturation and threshold test
  logic [POTENTIAL_BITS-1:0] s1_old_pot;
  logic [SUM_W-1:0]          s1_sum;
  logic [SUM_W-1:0]          s1_sat;
  logic                      s1_fire;

  always_comb begin
    s1_old_pot = (fwd_valid && (fwd_addr == s1_addr)) ? fwd_data : mem_rdata;
    s1_sum     = SUM_W'(s1_old_pot) + SUM_W'(spike_weight);
    s1_sat     = (s1_sum > POT_MAX) ? POT_MAX : s1_sum;
    s1_fire    = (s1_sat >= SUM_W'(fire_threshold));
    s1_new_pot = s1_fire ? '0 : s1_sat[POTENTIAL_BITS-1:0];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go) begin
      out_valid <= s1_valid && s1_hit && s1_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_channel <= s1_channel;
      out_row     <= s1_prow;
      out_col     <= s1_pcol;
    end
  end

  // checks
  a_no_request_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clr_active |-> !in_ready && !s1_valid && !out_valid)
    else $error("request path active during clearing sweep");

  a_held_request_keeps_cell: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_go |-> !mem_we ##1 (s1_valid && $stable(s1_addr)))
    else $error("stalled update lost its cell or wrote early");

  a_spike_from_hit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_valid && s1_hit))
    else $error("pooled spike without an in-range request");

  a_fwd_tracks_write: assert property (@(posedge clk) disable iff (rst)
    s1_write |=> fwd_valid && fwd_addr == $past(s1_addr))
    else $error("forwarding register missed a write-back");

endmodule

/* tb/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import spif_pkg::*;

  localparam int unsigned POT_W = POTENTIAL_BITS_DEFAULT;
  localparam int unsigned CELL_W = CH_W + OUT_ROW_W + OUT_COL_W;
  localparam int unsigned CELL_COUNT = 1 << CELL_W;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned DRAIN_LIMIT = 20000;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned HOT_CELLS = 4;

  // indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 2'd3;

  typedef struct packed {
    logic [CH_W-1:0]      ch;
    logic [OUT_ROW_W-1:0] row;
    logic [OUT_COL_W-1:0] col;
  } pooled_spike_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [CH_W-1:0]       channel = '0;
  logic [ROW_W-1:0]      row = '0;
  logic [COL_W-1:0]      col = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [CH_W-1:0]       out_channel;
  logic [OUT_ROW_W-1:0]  out_row;
  logic [OUT_COL_W-1:0]  out_col;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // predictor state
  logic [POT_W-1:0]      cell_level [CELL_COUNT];
  logic [CFG_DATA_W-1:0] pred_threshold = THRESHOLD_RESET;
  logic [CFG_DATA_W-1:0] pred_weight = WEIGHT_RESET;
  pooled_spike_t         expected_spikes [$];
  int unsigned           error_count = 0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  spiking_pool_integrate_fire_unit DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .channel    (channel),
    .row        (row),
    .col        (col),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_channel(out_channel),
    .out_row    (out_row),
    .out_col    (out_col),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    foreach (cell_level[i]) cell_level[i] = '0;
  end

  // integrate one spike into its pooled cell, report whether it fires
  function automatic bit integrate_spike(input logic [CH_W-1:0] ch,
                                         input logic [ROW_W-1:0] r,
                                         input logic [COL_W-1:0] c,
                                         output pooled_spike_t spike);
    logic [CELL_W-1:0] cell_idx;
    logic [POT_W:0]    sum;
    logic [POT_W-1:0]  level;
    cell_idx = {ch, r[ROW_W-1:1], c[COL_W-1:1]};
    sum = {1'b0, cell_level[cell_idx]} + {1'b0, pred_weight};
    // saturate at the top of the potential range
    level = sum[POT_W] ? '1 : sum[POT_W-1:0];
    spike.ch = ch;
    spike.row = r[ROW_W-1:1];
    spike.col = c[COL_W-1:1];
    if (level >= pred_threshold) begin
      cell_level[cell_idx] = '0;
      return 1'b1;
    end
    cell_level[cell_idx] = level;
    return 1'b0;
  endfunction

  // receiver back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // predict on accepted requests, check emitted pooled spikes
  always @(posedge clk) begin
    pooled_spike_t predicted;
    pooled_spike_t oldest;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FIRE_THRESHOLD: pred_threshold = cfg_data;
          REG_SPIKE_WEIGHT:   pred_weight = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready && integrate_spike(channel, row, col, predicted)) begin
        expected_spikes.push_back(predicted);
      end
      if (out_valid && out_ready) begin
        if (expected_spikes.size() == 0) begin
          $error("unexpected pooled spike ch=%0d row=%0d col=%0d",
                 out_channel, out_row, out_col);
          error_count++;
        end else begin
          oldest = expected_spikes.pop_front();
          if (out_channel !== oldest.ch) begin
            $error("out_channel expected %0d actual %0d", oldest.ch, out_channel);
            error_count++;
          end
          if (out_row !== oldest.row) begin
            $error("out_row expected %0d actual %0d", oldest.row, out_row);
            error_count++;
          end
          if (out_col !== oldest.col) begin
            $error("out_col expected %0d actual %0d", oldest.col, out_col);
            error_count++;
          end
        end
      end
    end
  end

  // send one spike request, held until accepted
  task automatic send_spike(input logic [CH_W-1:0] ch, input logic [ROW_W-1:0] r,
                            input logic [COL_W-1:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    channel <= ch;
    row <= r;
    col <= c;
    do @(posedge clk); while (!in_ready);
  endtask

  // let the block go idle, then write threshold, an unmapped index and weight
  task automatic program_regs(input logic [CFG_DATA_W-1:0] thr,
                              input logic [CFG_DATA_W-1:0] wgt);
    logic [CFG_IDX_W-1:0]  idx_seq [3];
    logic [CFG_DATA_W-1:0] data_seq [3];
    idx_seq[0] = REG_FIRE_THRESHOLD;
    idx_seq[1] = $urandom_range(1) ? REG_UNMAPPED_HI : REG_UNMAPPED_LO;
    idx_seq[2] = REG_SPIKE_WEIGHT;
    data_seq[0] = thr;
    data_seq[1] = CFG_DATA_W'($urandom_range(65535));
    data_seq[2] = wgt;
    in_valid <= 1'b0;
    while (expected_spikes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx_seq[i];
      cfg_data <= data_seq[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  // random spikes, mostly aimed at a few pooled cells so they build up and fire
  task automatic random_spikes(input int unsigned count);
    logic [CH_W-1:0]      hot_ch [HOT_CELLS];
    logic [OUT_ROW_W-1:0] hot_row [HOT_CELLS];
    logic [OUT_COL_W-1:0] hot_col [HOT_CELLS];
    int unsigned          sent;
    int unsigned          k;
    sent = 0;
    for (int i = 0; i < HOT_CELLS; i++) begin
      hot_ch[i] = CH_W'($urandom_range(15));
      hot_row[i] = OUT_ROW_W'($urandom_range(7));
      hot_col[i] = OUT_COL_W'($urandom_range(7));
    end
    while (sent < count) begin
      if ($urandom_range(3) != 0) begin
        k = $urandom_range(HOT_CELLS - 1);
        send_spike(hot_ch[k], {hot_row[k], 1'($urandom_range(1))},
                   {hot_col[k], 1'($urandom_range(1))});
      end else begin
        send_spike(CH_W'($urandom_range(15)), ROW_W'($urandom_range(15)),
                   COL_W'($urandom_range(15)));
      end
      sent++;
    end
  endtask

  // reset levels, whole 2x2 windows at the field extremes and one spike in between
  task automatic test_reset_levels_directed();
    send_spike(4'd0, 4'd0, 4'd0);
    send_spike(4'd0, 4'd0, 4'd1);
    send_spike(4'd0, 4'd1, 4'd0);
    send_spike(4'd0, 4'd1, 4'd1);
    send_spike(4'd15, 4'd15, 4'd15);
    send_spike(4'd15, 4'd14, 4'd14);
    send_spike(4'd15, 4'd15, 4'd14);
    send_spike(4'd15, 4'd14, 4'd15);
    send_spike(4'd5, 4'd10, 4'd3);
  endtask

  // zero threshold with zero weight: every spike fires at once
  task automatic test_zero_threshold();
    program_regs(16'd0, 16'd0);
    send_spike(4'd15, 4'd0, 4'd15);
    send_spike(4'd0, 4'd15, 4'd0);
    send_spike(4'd10, 4'd5, 4'd5);
  endtask

  // potential clamps at the top of the range and still fires at full threshold
  task automatic test_saturation();
    program_regs(16'hFFFF, 16'd40000);
    send_spike(4'd3, 4'd6, 4'd9);
    send_spike(4'd3, 4'd7, 4'd8);
    send_spike(4'd3, 4'd6, 4'd9);
    program_regs(16'hFFFF, 16'hFFFF);
    send_spike(4'd3, 4'd6, 4'd9);
    send_spike(4'd1, 4'd2, 4'd3);
  endtask

  // zero weight never reaches a non-zero threshold; then weight one reaches threshold one
  task automatic test_zero_weight();
    program_regs(16'd1, 16'd0);
    send_spike(4'd7, 4'd7, 4'd7);
    send_spike(4'd7, 4'd6, 4'd6);
    program_regs(16'd1, 16'd1);
    send_spike(4'd7, 4'd7, 4'd7);
  endtask

  task automatic test_random_reset_levels(input int unsigned count);
    program_regs(THRESHOLD_RESET, WEIGHT_RESET);
    random_spikes(count);
  endtask

  task automatic test_random_saturation(input int unsigned count);
    program_regs(16'hFFFF, CFG_DATA_W'($urandom_range(4096, 65535)));
    random_spikes(count);
  endtask

  task automatic test_random_zero_threshold(input int unsigned count);
    program_regs(16'd0, CFG_DATA_W'($urandom_range(65535)));
    random_spikes(count);
  endtask

  // random weight with a threshold at most twelve spikes away
  task automatic test_random_mixed_levels(input int unsigned count);
    int unsigned wgt;
    int unsigned thr_top;
    wgt = $urandom_range(1, 4096);
    thr_top = wgt * 12;
    if (thr_top > 65535) thr_top = 65535;
    program_regs(CFG_DATA_W'($urandom_range(thr_top)), CFG_DATA_W'(wgt));
    random_spikes(count);
  endtask

  // watchdog
  initial begin
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("testbench: errors");
    $finish;
  end

  // test sequence
  initial begin
    int unsigned drain_cycles;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    // potential store clears after reset with in_ready low
    do @(posedge clk); while (!in_ready);

    send_idle_pct = 27;
    recv_idle_pct = 80;
    test_reset_levels_directed();
    test_zero_threshold();
    test_saturation();
    test_zero_weight();
    test_random_reset_levels(175);
    test_random_saturation(175);

    send_idle_pct = 80;
    recv_idle_pct = 27;
    test_random_zero_threshold(175);
    test_random_mixed_levels(175);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_mixed_levels(175);
    test_random_mixed_levels(175);

    // drain outstanding pooled spikes
    in_valid <= 1'b0;
    drain_cycles = 0;
    while (expected_spikes.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_spikes.size() != 0) begin
      $error("%0d pooled spikes never emitted", expected_spikes.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
